// ===== hdl/gbl_pkg.sv =====
`default_nettype none
package gbl_pkg;

   localparam int EDGE       = 64;
   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = $clog2(EDGE);
   localparam int VAL_W      = 32;
   localparam int POS_W      = COORD_W + FRAC_BITS;
   localparam int BANK_AW    = 2 * (COORD_W - 1);
   localparam int BANK_DEPTH = (EDGE * EDGE) / 4;
   localparam int PROD_W     = VAL_W + FRAC_BITS + 1;

   // request payload: col, row, value, x, y packed from bit 0 up
   localparam int REQ_BITS    = 2 * COORD_W + 3 * VAL_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int OFS_ROW     = COORD_W;
   localparam int OFS_VALUE   = 2 * COORD_W;
   localparam int OFS_QX      = OFS_VALUE + VAL_W;
   localparam int OFS_QY      = OFS_QX + VAL_W;

   localparam logic [FRAC_BITS:0] ONE_FX    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [31:0]        VPM_RESET = 32'd1 << FRAC_BITS;

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_QUERY = 1'b1
   } gbl_mode_type;

   // item leaving the scaling pipe, at the table access stage
   typedef struct packed {
      logic               valid;
      logic               query;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [VAL_W-1:0]   value;
      logic [POS_W-1:0]   px;
      logic [POS_W-1:0]   py;
   } gbl_item_type;

   // query context that travels alongside the bank read data
   typedef struct packed {
      logic                 valid;
      logic [FRAC_BITS-1:0] fx;
      logic [FRAC_BITS-1:0] fy;
      logic                 x_odd;
      logic                 x_edge;
      logic                 y_odd;
      logic                 y_edge;
   } gbl_tap_type;

endpackage
`default_nettype wire

// ===== hdl/grid_bilinear_lookup.sv =====
`default_nettype none
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser: mode; tdata: col, row, value, x, y
// rsp       out  rsp_tvalid/rsp_tready  tdata: interpolated value
// csr       in   csr_valid/csr_ready    data: voxels_per_meter (Q16.16)
//
// One request per cycle while req_tready is high, writes and queries alike.
// The four neighbors come from four parity banks (even/odd column x even/odd
// row), one read port each, so a query needs one table access. Reset clears
// the pipe and sets the scale to 1.0; table contents are undefined until
// written and are not cleared. The pipe freezes while the output skid holds a
// second result; req_tready then drops.
module grid_bilinear_lookup
   import gbl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // write_col, write_row, write_value,
                                                   // query_x, query_y, zero fill
   input  wire logic                   req_tuser,  // mode
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [VAL_W-1:0]       rsp_tdata,  // interpolated_value
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [31:0]            csr_data
);

   logic                       en;
   logic [31:0]                vpm_ff;
   gbl_item_type               item;
   gbl_tap_type                tap_ff, tap_in;
   logic [1:0][1:0][VAL_W-1:0] rd_data;
   logic [1:0][1:0][BANK_AW-1:0] rd_addr;
   logic [BANK_AW-1:0]         wr_addr;
   logic [COORD_W-1:0]         x0, y0;
   logic [COORD_W:0]           x0p1, y0p1;
   logic [COORD_W-2:0]         xh [2];
   logic [COORD_W-2:0]         yh [2];
   logic                       res_valid;
   logic [VAL_W-1:0]           res_value;
   logic                       out_valid_ff, out_valid_in;
   logic [VAL_W-1:0]           out_data_ff, out_data_in;
   logic                       skid_valid_ff, skid_valid_in;
   logic [VAL_W-1:0]           skid_data_ff, skid_data_in;
   logic                       take, push;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vpm_ff <= VPM_RESET;
      end else if (csr_valid) begin
         vpm_ff <= csr_data;
      end
   end

   gbl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_tvalid),
      .req_mode  (gbl_mode_type'(req_tuser)),
      .req_col   (req_tdata[COORD_W-1:0]),
      .req_row   (req_tdata[OFS_ROW +: COORD_W]),
      .req_value (req_tdata[OFS_VALUE +: VAL_W]),
      .req_qx    (req_tdata[OFS_QX +: VAL_W]),
      .req_qy    (req_tdata[OFS_QY +: VAL_W]),
      .vpm       (vpm_ff),
      .item      (item)
   );

   // even bank holds lower+1 when lower is odd; past the edge that read is unused
   always_comb begin
      x0    = item.px[POS_W-1:FRAC_BITS];
      y0    = item.py[POS_W-1:FRAC_BITS];
      x0p1  = {1'b0, x0} + (COORD_W+1)'(1);
      y0p1  = {1'b0, y0} + (COORD_W+1)'(1);
      xh[0] = x0p1[COORD_W-1:1];
      xh[1] = x0[COORD_W-1:1];
      yh[0] = y0p1[COORD_W-1:1];
      yh[1] = y0[COORD_W-1:1];
      for (int r = 0; r < 2; r++) begin
         for (int c = 0; c < 2; c++) begin
            rd_addr[r][c] = {yh[r], xh[c]};
         end
      end
      wr_addr = {item.row[COORD_W-1:1], item.col[COORD_W-1:1]};

      tap_in.valid  = item.valid & item.query;
      tap_in.fx     = item.px[FRAC_BITS-1:0];
      tap_in.fy     = item.py[FRAC_BITS-1:0];
      tap_in.x_odd  = x0[0];
      tap_in.x_edge = (x0 == COORD_W'(EDGE - 1));
      tap_in.y_odd  = y0[0];
      tap_in.y_edge = (y0 == COORD_W'(EDGE - 1));
   end

   for (genvar r = 0; r < 2; r++) begin : g_row
      for (genvar c = 0; c < 2; c++) begin : g_col
         gbl_bank u_bank (
            .clock   (clock),
            .wr_en   (en & item.valid & !item.query
                      & (item.row[0] == 1'(r)) & (item.col[0] == 1'(c))),
            .wr_addr (wr_addr),
            .wr_data (item.value),
            .rd_en   (en),
            .rd_addr (rd_addr[r][c]),
            .rd_data (rd_data[r][c])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff.valid <= 1'b0;
      end else if (en) begin
         tap_ff.valid <= tap_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff.fx     <= tap_in.fx;
         tap_ff.fy     <= tap_in.fy;
         tap_ff.x_odd  <= tap_in.x_odd;
         tap_ff.x_edge <= tap_in.x_edge;
         tap_ff.y_odd  <= tap_in.y_odd;
         tap_ff.y_edge <= tap_in.y_edge;
      end
   end

   gbl_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .tap       (tap_ff),
      .smp       (rd_data),
      .res_valid (res_valid),
      .res_value (res_value)
   );

   // output register plus skid
   always_comb begin
      take          = out_valid_ff & rsp_tready;
      push          = en & res_valid;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = res_value;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = res_value;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

// ===== hdl/gbl_bank.sv =====
`default_nettype none
module gbl_bank
   import gbl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [BANK_AW-1:0] wr_addr,
   input  wire logic [VAL_W-1:0]   wr_data,
   input  wire logic               rd_en,
   input  wire logic [BANK_AW-1:0] rd_addr,
   output logic      [VAL_W-1:0]   rd_data
);

   logic [VAL_W-1:0] mem [BANK_DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/gbl_scale.sv =====
`default_nettype none
module gbl_scale
   import gbl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               req_valid,
   input  wire gbl_mode_type       req_mode,
   input  wire logic [COORD_W-1:0] req_col,
   input  wire logic [COORD_W-1:0] req_row,
   input  wire logic [VAL_W-1:0]   req_value,
   input  wire logic [VAL_W-1:0]   req_qx,
   input  wire logic [VAL_W-1:0]   req_qy,
   input  wire logic [31:0]        vpm,
   output gbl_item_type            item
);

   localparam int PW = 64 - FRAC_BITS + 1;
   localparam logic signed [PW-1:0] HALF = PW'(EDGE / 2) << FRAC_BITS;
   localparam logic signed [PW-1:0] HI   = PW'(EDGE - 1) << FRAC_BITS;

   // drop the extra fraction bits (floor), add the center offset, clamp to grid
   function automatic logic [POS_W-1:0] clamp_pos(input logic [63:0] prod);
      logic signed [PW-1:0] pos;
      pos = $signed({prod[63], prod[63:FRAC_BITS]}) + HALF;
      if (pos < 0) begin
         clamp_pos = '0;
      end else if (pos > HI) begin
         clamp_pos = HI[POS_W-1:0];
      end else begin
         clamp_pos = pos[POS_W-1:0];
      end
   endfunction

   logic               s1_valid_ff, s1_query_ff;
   logic [COORD_W-1:0] s1_col_ff, s1_row_ff;
   logic [VAL_W-1:0]   s1_value_ff, s1_qx_ff, s1_qy_ff;

   logic               s2_valid_ff, s2_query_ff;
   logic [COORD_W-1:0] s2_col_ff, s2_row_ff;
   logic [VAL_W-1:0]   s2_value_ff;
   logic [63:0]        s2_prodx_ff, s2_prody_ff;
   logic [63:0]        s2_prodx_in, s2_prody_in;

   logic               s3_valid_ff, s3_query_ff;
   logic [COORD_W-1:0] s3_col_ff, s3_row_ff;
   logic [VAL_W-1:0]   s3_value_ff;
   logic [POS_W-1:0]   s3_px_ff, s3_py_ff;

   always_comb begin
      s2_prodx_in = $signed({{32{s1_qx_ff[31]}}, s1_qx_ff}) * $signed({32'd0, vpm});
      s2_prody_in = $signed({{32{s1_qy_ff[31]}}, s1_qy_ff}) * $signed({32'd0, vpm});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_query_ff <= (req_mode == MODE_QUERY);
         s1_col_ff   <= req_col;
         s1_row_ff   <= req_row;
         s1_value_ff <= req_value;
         s1_qx_ff    <= req_qx;
         s1_qy_ff    <= req_qy;

         s2_query_ff <= s1_query_ff;
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;
         s2_value_ff <= s1_value_ff;
         s2_prodx_ff <= s2_prodx_in;
         s2_prody_ff <= s2_prody_in;

         s3_query_ff <= s2_query_ff;
         s3_col_ff   <= s2_col_ff;
         s3_row_ff   <= s2_row_ff;
         s3_value_ff <= s2_value_ff;
         s3_px_ff    <= clamp_pos(s2_prodx_ff);
         s3_py_ff    <= clamp_pos(s2_prody_ff);
      end
   end

   always_comb begin
      item.valid = s3_valid_ff;
      item.query = s3_query_ff;
      item.col   = s3_col_ff;
      item.row   = s3_row_ff;
      item.value = s3_value_ff;
      item.px    = s3_px_ff;
      item.py    = s3_py_ff;
   end

endmodule
`default_nettype wire

// ===== hdl/gbl_blend.sv =====
`default_nettype none
module gbl_blend
   import gbl_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire gbl_tap_type                 tap,
   input  wire logic [1:0][1:0][VAL_W-1:0]  smp,   // [row parity][col parity]
   output logic                             res_valid,
   output logic      [VAL_W-1:0]            res_value
);

   localparam int HIN_W = PROD_W - FRAC_BITS;
   localparam int H_W   = PROD_W + 1;
   localparam int L_W   = 2 * FRAC_BITS + 1;
   localparam int S_W   = H_W + 1;

   function automatic logic [PROD_W-1:0] mul_sample(input logic [VAL_W-1:0] s,
                                                    input logic [FRAC_BITS:0] w);
      mul_sample = $signed({{(PROD_W-VAL_W){s[VAL_W-1]}}, s})
                 * $signed({{(PROD_W-FRAC_BITS-1){1'b0}}, w});
   endfunction

   function automatic logic [H_W-1:0] mul_whole(input logic [HIN_W-1:0] h,
                                                input logic [FRAC_BITS:0] w);
      mul_whole = $signed({{(H_W-HIN_W){h[HIN_W-1]}}, h})
                * $signed({{(H_W-FRAC_BITS-1){1'b0}}, w});
   endfunction

   // x step
   logic                 cx0, cx1, ry0, ry1;
   logic [FRAC_BITS:0]   wx0, wx1;
   logic                 v5_ff, v6_ff, v7_ff;
   logic [FRAC_BITS-1:0] fy5_ff, fy6_ff;
   logic [PROD_W-1:0]    p00_ff, p10_ff, p01_ff, p11_ff;
   logic [PROD_W-1:0]    r0_ff, r1_ff;

   // y step, kept exact by splitting each row sum into whole and fraction
   logic [FRAC_BITS:0]   wy0, wy1;
   logic [H_W-1:0]       hp0_ff, hp1_ff;
   logic [L_W-1:0]       lp0_ff, lp1_ff;
   logic [S_W-1:0]       hsum, total;
   logic [L_W:0]         lsum;

   always_comb begin
      // upper neighbor sits in the other parity bank, except on the last cell
      cx0 = tap.x_odd;
      cx1 = !tap.x_odd | tap.x_edge;
      ry0 = tap.y_odd;
      ry1 = !tap.y_odd | tap.y_edge;
      wx1 = {1'b0, tap.fx};
      wx0 = ONE_FX - wx1;
      wy1 = {1'b0, fy6_ff};
      wy0 = ONE_FX - wy1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= tap.valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fy5_ff <= tap.fy;
         p00_ff <= mul_sample(smp[ry0][cx0], wx0);
         p10_ff <= mul_sample(smp[ry0][cx1], wx1);
         p01_ff <= mul_sample(smp[ry1][cx0], wx0);
         p11_ff <= mul_sample(smp[ry1][cx1], wx1);

         fy6_ff <= fy5_ff;
         r0_ff  <= p00_ff + p10_ff;
         r1_ff  <= p01_ff + p11_ff;

         hp0_ff <= mul_whole(r0_ff[PROD_W-1:FRAC_BITS], wy0);
         hp1_ff <= mul_whole(r1_ff[PROD_W-1:FRAC_BITS], wy1);
         lp0_ff <= {{(L_W-FRAC_BITS){1'b0}}, r0_ff[FRAC_BITS-1:0]}
                 * {{(L_W-FRAC_BITS-1){1'b0}}, wy0};
         lp1_ff <= {{(L_W-FRAC_BITS){1'b0}}, r1_ff[FRAC_BITS-1:0]}
                 * {{(L_W-FRAC_BITS-1){1'b0}}, wy1};
      end
   end

   always_comb begin
      hsum  = {hp0_ff[H_W-1], hp0_ff} + {hp1_ff[H_W-1], hp1_ff};
      lsum  = {1'b0, lp0_ff} + {1'b0, lp1_ff};
      total = hsum + {{(S_W-(L_W+1-FRAC_BITS)){1'b0}}, lsum[L_W:FRAC_BITS]};
   end

   assign res_valid = v7_ff;
   assign res_value = total[FRAC_BITS +: VAL_W];

endmodule
`default_nettype wire

// ===== tb/tb_grid_bilinear_lookup.sv =====
`timescale 1ns / 1ps
module tb_grid_bilinear_lookup;
   import gbl_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;  // write_col, write_row, write_value, query_x, query_y
   logic                   req_tuser;  // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [VAL_W-1:0]       rsp_tdata;  // interpolated_value
   logic                   csr_valid;
   logic                   csr_ready;
   logic [31:0]            csr_data;

   grid_bilinear_lookup u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // predictor state
   logic [VAL_W-1:0] cost_grid [EDGE*EDGE];
   logic [31:0]      cells_per_meter;
   logic [VAL_W-1:0] expected_costs [$];
   int unsigned      fail_count;
   bit               sender_burst;
   bit               receiver_burst;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int unsigned pick_gap(bit burst);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (burst || r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // clamped grid position, FRAC_BITS fraction bits
   function automatic longint grid_pos(logic [31:0] q);
      longint p;
      longint top;
      top = longint'(EDGE - 1) <<< FRAC_BITS;
      p = (longint'($signed(q)) * longint'({32'd0, cells_per_meter})) >>> FRAC_BITS;
      p = p + (longint'(EDGE / 2) <<< FRAC_BITS);
      if (p < 0)
         p = 0;
      if (p > top)
         p = top;
      return p;
   endfunction

   function automatic longint cell_at(longint col, longint row);
      return longint'($signed(cost_grid[col + EDGE * row]));
   endfunction

   function automatic logic [VAL_W-1:0] interp_cost(logic [31:0] qx, logic [31:0] qy);
      longint one, px, py, x0, y0, x1, y1, fx, fy;
      longint r0, r1, h0, h1, l0, l1, hsum, lsum, res;
      one = longint'(1) <<< FRAC_BITS;
      px = grid_pos(qx);
      py = grid_pos(qy);
      x0 = px >>> FRAC_BITS;
      fx = px & (one - 1);
      y0 = py >>> FRAC_BITS;
      fy = py & (one - 1);
      x1 = (x0 + 1 < EDGE) ? x0 + 1 : x0;
      y1 = (y0 + 1 < EDGE) ? y0 + 1 : y0;
      r0 = cell_at(x0, y0) * (one - fx) + cell_at(x1, y0) * fx;
      r1 = cell_at(x0, y1) * (one - fx) + cell_at(x1, y1) * fx;
      // split rows so the y step stays inside 64 bits
      h0 = r0 >>> FRAC_BITS;
      l0 = r0 - (h0 <<< FRAC_BITS);
      h1 = r1 >>> FRAC_BITS;
      l1 = r1 - (h1 <<< FRAC_BITS);
      hsum = h0 * (one - fy) + h1 * fy;
      lsum = l0 * (one - fy) + l1 * fy;
      res = (hsum + (lsum >>> FRAC_BITS)) >>> FRAC_BITS;
      return res[VAL_W-1:0];
   endfunction

   // position in meters that lands near the grid at the current scale
   function automatic logic [31:0] pick_coord();
      longint cells, m;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 15 || cells_per_meter == 0)
         return $urandom();
      cells = longint'($urandom_range(0, 70 << FRAC_BITS)) - (longint'(35) <<< FRAC_BITS);
      if (sel < 30)
         cells = (cells >>> FRAC_BITS) <<< FRAC_BITS;
      m = (cells <<< FRAC_BITS) / longint'({32'd0, cells_per_meter});
      if (m > 64'sh7FFF_FFFF)
         m = 64'sh7FFF_FFFF;
      if (m < -64'sh8000_0000)
         m = -64'sh8000_0000;
      return m[31:0];
   endfunction

   task automatic send_request(input gbl_mode_type mode, input logic [COORD_W-1:0] col,
                               input logic [COORD_W-1:0] row, input logic [31:0] value,
                               input logic [31:0] qx, input logic [31:0] qy);
      logic [REQ_TDATA_W-1:0] word;
      int unsigned gap;
      word = '0;
      word[COORD_W-1:0] = col;
      word[OFS_ROW +: COORD_W] = row;
      word[OFS_VALUE +: VAL_W] = value;
      word[OFS_QX +: VAL_W] = qx;
      word[OFS_QY +: VAL_W] = qy;
      gap = pick_gap(sender_burst);
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (mode == MODE_WRITE)
         cost_grid[col + EDGE * row] = value;
      else
         expected_costs.push_back(interp_cost(qx, qy));
   endtask

   task automatic write_cost(input int col, input int row, input logic [31:0] value);
      send_request(MODE_WRITE, col[COORD_W-1:0], row[COORD_W-1:0], value,
                   $urandom(), $urandom());
   endtask

   task automatic query_cost(input logic [31:0] qx, input logic [31:0] qy);
      send_request(MODE_QUERY, COORD_W'($urandom_range(0, EDGE - 1)),
                   COORD_W'($urandom_range(0, EDGE - 1)), $urandom(), qx, qy);
   endtask

   // drop valid, let every pending result and any write still in the pipe drain
   task automatic wait_idle();
      @(negedge clock) req_tvalid <= 1'b0;
      while (expected_costs.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_scale(input logic [31:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      cells_per_meter = value;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic fill_cost_table();
      logic [31:0] value;
      for (int row = 0; row < EDGE; row++) begin
         if (row % 8 == 0)
            sender_burst = ($urandom_range(0, 3) == 0);
         for (int col = 0; col < EDGE; col++) begin
            case ($urandom_range(0, 19))
               0: value = 32'h7FFF_FFFF;
               1: value = 32'h8000_0000;
               2: value = 32'h0000_0000;
               default: value = $urandom();
            endcase
            write_cost(col, row, value);
         end
      end
   endtask

   // scale 1.0: corners, edges, clamping, whole and fractional positions
   task automatic test_directed_extremes();
      sender_burst = 1'b1;
      write_cost(0, 0, 32'h8000_0000);
      write_cost(1, 0, 32'h7FFF_FFFF);
      write_cost(0, 1, 32'h7FFF_FFFF);
      write_cost(EDGE - 1, EDGE - 1, 32'h7FFF_FFFF);
      write_cost(EDGE - 2, EDGE - 1, 32'h8000_0000);
      query_cost(32'h8000_0000, 32'h8000_0000);
      query_cost(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      query_cost(32'hFFE0_8000, 32'hFFE0_0000);
      query_cost(32'hFFE0_4000, 32'hFFE0_C000);
      query_cost(32'h001F_0000, 32'h001F_0000);
      query_cost(32'h001E_8000, 32'h001F_0000);
      query_cost(32'h0000_0000, 32'h0000_0000);
      query_cost(32'hFFFF_FFFF, 32'h0000_0001);
      query_cost(32'h0000_8000, 32'hFFFF_C000);
      query_cost(32'hFFD0_0000, 32'h0040_0000);
      // read right behind the write to the same cells
      write_cost(EDGE / 2, EDGE / 2, 32'h1234_5678);
      query_cost(32'h0000_0000, 32'h0000_0000);
      write_cost(EDGE / 2 + 1, EDGE / 2, 32'hFEDC_BA98);
      query_cost(32'h0000_8000, 32'h0000_0000);
      sender_burst = 1'b0;
   endtask

   task automatic test_scale_limits();
      // zero scale maps every query onto the center cell
      write_scale(32'h0000_0000);
      query_cost($urandom(), $urandom());
      query_cost(32'h8000_0000, 32'h7FFF_FFFF);
      write_scale(32'hFFFF_FFFF);
      query_cost(32'h0000_0001, 32'hFFFF_FFFF);
      query_cost(32'h8000_0000, 32'h7FFF_FFFF);
      write_scale(32'h0000_0001);
      query_cost(32'h7FFF_FFFF, 32'h8000_0000);
      query_cost($urandom(), $urandom());
   endtask

   task automatic run_random_phase(input logic [31:0] scale, input int count,
                                   input bit pause_mid);
      logic [31:0] value;
      write_scale(scale);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            sender_burst   = ($urandom_range(0, 3) == 0);
            receiver_burst = ($urandom_range(0, 3) == 0);
         end
         if (pause_mid && i == count / 2)
            wait_idle();
         if ($urandom_range(0, 9) < 3) begin
            case ($urandom_range(0, 9))
               0: value = 32'h7FFF_FFFF;
               1: value = 32'h8000_0000;
               default: value = $urandom();
            endcase
            write_cost($urandom_range(0, EDGE - 1), $urandom_range(0, EDGE - 1), value);
         end else begin
            query_cost(pick_coord(), pick_coord());
         end
      end
   endtask

   task automatic test_random_mix();
      run_random_phase(32'h0001_0000, 270, 1'b0);
      run_random_phase(32'h0000_4000, 260, 1'b1);
      run_random_phase(32'h0002_8000, 270, 1'b0);
      run_random_phase(32'h0000_0001, 200, 1'b0);
      run_random_phase(32'hFFFF_FFFF, 200, 1'b0);
      run_random_phase(32'h0000_0000, 150, 1'b0);
      run_random_phase($urandom_range(32'h0000_1000, 32'h0008_0000), 270, 1'b1);
      run_random_phase(32'h0001_0000, 200, 1'b0);
   endtask

   // result side: random backpressure
   initial begin
      int unsigned run_len;
      int unsigned stall;
      rsp_tready = 1'b0;
      forever begin
         run_len = $urandom_range(1, 16);
         stall   = pick_gap(receiver_burst);
         @(negedge clock) rsp_tready <= 1'b1;
         repeat (run_len - 1) @(negedge clock);
         if (stall > 0) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_costs.size() == 0) begin
            $display("%0t: unexpected interpolated_value %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            if (rsp_tdata !== expected_costs[0]) begin
               $display("%0t: interpolated_value expected %h actual %h",
                        $time, expected_costs[0], rsp_tdata);
               fail_count++;
            end
            void'(expected_costs.pop_front());
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = MODE_WRITE;
      csr_valid       = 1'b0;
      csr_data        = '0;
      cells_per_meter = VPM_RESET;
      fail_count      = 0;
      sender_burst    = 1'b0;
      receiver_burst  = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      fill_cost_table();
      test_directed_extremes();
      test_scale_limits();
      test_random_mix();
      wait_idle();

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
